/* rtl/core/iirbq_pkg.sv */
// ----------------------------------------------------------------------------
// IIR biquad cascade package
// Shared widths, coefficient codes and arithmetic helpers for the cascade.
// ----------------------------------------------------------------------------
`default_nettype none

package iirbq_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 32;
   localparam int WORD_W   = 48;
   localparam int ACC_W    = 60;
   localparam int PROD_W   = COEF_W + WORD_W;
   localparam int SEL_W    = 3;
   localparam int SECNUM_W = 4;
   localparam int NCOEF    = 5;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [SEL_W-1:0]         sel_type;

   localparam sel_type COEF_B0 = 3'd0;
   localparam sel_type COEF_B1 = 3'd1;
   localparam sel_type COEF_B2 = 3'd2;
   localparam sel_type COEF_A1 = 3'd3;
   localparam sel_type COEF_A2 = 3'd4;

   // Clamp a wide exact sum to the signed 48-bit range.
   function automatic word_type sat48(input acc_type v);
      logic [ACC_W-WORD_W:0] top;
      top = v[ACC_W-1:WORD_W-1];
      if (!v[ACC_W-1] && (top != '0)) begin
         sat48 = {1'b0, {(WORD_W-1){1'b1}}};
      end else if (v[ACC_W-1] && (top != '1)) begin
         sat48 = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         sat48 = v[WORD_W-1:0];
      end
   endfunction

   // Truncate a Q32.16 word toward zero and saturate to 16 bits.
   function automatic logic [SAMPLE_W-1:0] to_sample(input word_type y);
      logic [WORD_W-1:0] m;
      logic [31:0]       q;
      m = y[WORD_W-1] ? (~y + 1'b1) : y;
      q = m[WORD_W-1:16];
      if (!y[WORD_W-1]) begin
         to_sample = (q > 32'd32767) ? 16'h7FFF : q[15:0];
      end else begin
         to_sample = (q > 32'd32768) ? 16'h8000 : (~q[15:0] + 16'd1);
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/core/iir_biquad_cascade_unit.sv */
// ----------------------------------------------------------------------------
// IIR biquad cascade unit
// Direct-form-II second-order sections in cascade with a bit-serial multiplier.
// ----------------------------------------------------------------------------
//  Channel   Ports                                      Direction
//  request   req_valid/req_ready, req_mode..coef_value  in
//  response  rsp_valid/rsp_ready, rsp_sample_out        out
//
// A coefficient word completes in the cycle it is accepted. A sample word
// runs through the sections in turn; each section forms five products on the
// single shift-add multiplier, which retires one multiplier bit per cycle,
// and reads and writes its delay words. No new word is taken meanwhile.
// Reset clears coefficients and delay words through per-entry valid bits.
// A finished result waits in the output register while new words are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_biquad_cascade_unit #(
   parameter int SECTIONS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_mode,
   input  wire logic signed [iirbq_pkg::SAMPLE_W-1:0] req_sample_in,
   input  wire logic [iirbq_pkg::SECNUM_W-1:0]        req_coef_section,
   input  wire logic [iirbq_pkg::SEL_W-1:0]           req_coef_select,
   input  wire logic signed [iirbq_pkg::COEF_W-1:0]   req_coef_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [iirbq_pkg::SAMPLE_W-1:0]      rsp_sample_out
);
   import iirbq_pkg::*;

   localparam int CDEPTH  = SECTIONS * NCOEF;
   localparam int DDEPTH  = SECTIONS * 2;
   localparam int CADDR_W = $clog2(CDEPTH);
   localparam int DADDR_W = $clog2(DDEPTH);
   localparam int SEC_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_W0, ST_RD_W1, ST_GET_W1, ST_PREP, ST_LOAD,
      ST_MUL, ST_ACC, ST_WR_W1, ST_WR_W0, ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [SEC_W-1:0]        sec_ff, sec_in;
   logic [2:0]              k_ff, k_in;
   logic [5:0]              cnt_ff, cnt_in;
   word_type                x_ff, x_in;
   word_type                w0_ff, w0_in;
   word_type                w1_ff, w1_in;
   word_type                w_ff, w_in;
   acc_type                 acc_ff, acc_in;
   logic [COEF_W-1:0]       mc_ff, mc_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [COEF_W-1:0]       cmem [CDEPTH];
   logic [CDEPTH-1:0]       cvalid_ff;
   logic [COEF_W-1:0]       cq_ff;
   logic                    cv_ff;
   logic [WORD_W-1:0]       dmem [DDEPTH];
   logic [DDEPTH-1:0]       dvalid_ff;
   logic [WORD_W-1:0]       dq_ff;
   logic                    dv_ff;

   logic                    accept;
   logic                    cwr_en;
   logic [6:0]              cwr_full;
   logic [6:0]              crd_full;
   sel_type                 csel;
   logic [CADDR_W-1:0]      crd_addr;
   logic [SEC_W:0]          dsec;
   logic [DADDR_W-1:0]      drd_addr;
   logic                    dwr_en;
   logic [DADDR_W-1:0]      dwr_addr;
   word_type                dwr_data;
   word_type                dval;
   logic signed [COEF_W-1:0] cval;
   word_type                opd;
   logic [WORD_W-1:0]       md;
   logic [COEF_W:0]         sum33;
   acc_type                 term;
   acc_type                 acc_sum;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   assign cwr_en   = accept && req_mode
                     && ({1'b0, req_coef_section} < 5'(SECTIONS))
                     && (req_coef_select < sel_type'(NCOEF));
   assign cwr_full = {3'b000, req_coef_section} * 7'd5 + {4'b0000, req_coef_select};

   always_comb begin
      unique case (k_ff)
         3'd0:    csel = COEF_A1;
         3'd1:    csel = COEF_A2;
         3'd2:    csel = COEF_B0;
         3'd3:    csel = COEF_B1;
         default: csel = COEF_B2;
      endcase
   end

   assign crd_full = 7'(sec_ff) * 7'd5 + {4'b0000, csel};
   assign crd_addr = crd_full[CADDR_W-1:0];

   assign dsec     = (state_ff == ST_RD_W1 || state_ff == ST_WR_W1) ?
                     {sec_ff, 1'b1} : {sec_ff, 1'b0};
   assign drd_addr = dsec[DADDR_W-1:0];
   assign dwr_addr = dsec[DADDR_W-1:0];
   assign dwr_en   = (state_ff == ST_WR_W1) || (state_ff == ST_WR_W0);
   assign dwr_data = (state_ff == ST_WR_W1) ? w0_ff : w_ff;

   assign dval = dv_ff ? dq_ff : '0;
   assign cval = cv_ff ? cq_ff : '0;

   always_comb begin
      unique case (k_ff)
         3'd0, 3'd3: opd = w0_ff;
         3'd1, 3'd4: opd = w1_ff;
         default:    opd = w_ff;
      endcase
   end

   assign md    = opd[WORD_W-1] ? (~opd + 1'b1) : opd;
   assign sum33 = {1'b0, prod_ff[PROD_W-1:WORD_W]} + (prod_ff[0] ? {1'b0, mc_ff} : '0);
   assign term  = {{(ACC_W-(PROD_W-24)){1'b0}}, prod_ff[PROD_W-1:24]};
   assign acc_sum = (neg_ff ^ (k_ff < 3'd2)) ? (acc_ff - term) : (acc_ff + term);

   always_ff @(posedge clock) begin
      if (cwr_en) begin
         cmem[cwr_full[CADDR_W-1:0]] <= req_coef_value;
      end
      cq_ff <= cmem[crd_addr];
      if (dwr_en) begin
         dmem[dwr_addr] <= dwr_data;
      end
      dq_ff <= dmem[drd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff <= '0;
         dvalid_ff <= '0;
         cv_ff     <= 1'b0;
         dv_ff     <= 1'b0;
      end else begin
         if (cwr_en) begin
            cvalid_ff[cwr_full[CADDR_W-1:0]] <= 1'b1;
         end
         if (dwr_en) begin
            dvalid_ff[dwr_addr] <= 1'b1;
         end
         cv_ff <= cvalid_ff[crd_addr];
         dv_ff <= dvalid_ff[drd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sec_in       = sec_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      mc_in        = mc_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_mode) begin
               x_in     = {{(WORD_W-SAMPLE_W-16){req_sample_in[SAMPLE_W-1]}},
                           req_sample_in, 16'h0000};
               sec_in   = '0;
               state_in = ST_RD_W0;
            end
         end
         ST_RD_W0: state_in = ST_RD_W1;
         ST_RD_W1: begin
            w0_in    = dval;
            state_in = ST_GET_W1;
         end
         ST_GET_W1: begin
            w1_in    = dval;
            k_in     = '0;
            acc_in   = {{(ACC_W-WORD_W){x_ff[WORD_W-1]}}, x_ff};
            state_in = ST_PREP;
         end
         ST_PREP: state_in = ST_LOAD;
         ST_LOAD: begin
            mc_in    = cval[COEF_W-1] ? (~cval + 1'b1) : cval;
            neg_in   = cval[COEF_W-1] ^ opd[WORD_W-1];
            prod_in  = {{COEF_W{1'b0}}, md};
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = {sum33, prod_ff[WORD_W-1:1]};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'(WORD_W - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd1) begin
               w_in     = sat48(acc_sum);
               acc_in   = '0;
               state_in = ST_PREP;
            end else if (k_ff == 3'd4) begin
               x_in     = sat48(acc_sum);
               state_in = ST_WR_W1;
            end else begin
               acc_in   = acc_sum;
               state_in = ST_PREP;
            end
         end
         ST_WR_W1: state_in = ST_WR_W0;
         ST_WR_W0: begin
            if (sec_ff == SEC_W'(SECTIONS - 1)) begin
               state_in = ST_DONE;
            end else begin
               sec_in   = sec_ff + 1'b1;
               state_in = ST_RD_W0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = to_sample(x_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sec_ff       <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sec_ff       <= sec_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
      end
      x_ff        <= x_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      w_ff        <= w_in;
      acc_ff      <= acc_in;
      mc_ff       <= mc_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* test/tb_iir_biquad_cascade_unit.sv */
// ----------------------------------------------------------------------------
// IIR biquad cascade unit testbench
// Drives coefficient and sample words through the request channel, predicts
// every filtered sample with an independent fixed-point cascade model and
// compares each response word in order, under several idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_iir_biquad_cascade_unit;
   import iirbq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SECTIONS = 16;
   localparam int HOLD_CYCLES = 15000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_mode = 1'b0;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic [SECNUM_W-1:0]        req_coef_section = '0;
   logic [SEL_W-1:0]           req_coef_select = '0;
   logic signed [COEF_W-1:0]   req_coef_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;

   logic signed [COEF_W-1:0]   coef_bank [SECTIONS*NCOEF];
   longint                     delay_bank [SECTIONS*2];
   logic [SAMPLE_W-1:0]        filtered_q [$];

   int  error_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   iir_biquad_cascade_unit #(.SECTIONS(SECTIONS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_sample_in(req_sample_in), .req_coef_section(req_coef_section),
      .req_coef_select(req_coef_select), .req_coef_value(req_coef_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_word(input longint v);
      longint hi;
      hi = 64'sh0000_7FFF_FFFF_FFFF;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint coef_product(input longint c, input longint d);
      logic [127:0] p;
      logic [63:0]  mc;
      logic [63:0]  md;
      longint       m;
      mc = (c < 0) ? -c : c;
      md = (d < 0) ? -d : d;
      p = {64'd0, mc} * {64'd0, md};
      m = longint'(p >> 24);
      return ((c < 0) != (d < 0)) ? -m : m;
   endfunction

   function automatic logic [SAMPLE_W-1:0] filter_sample(input logic signed [15:0] s);
      longint x;
      longint y;
      longint w;
      longint w0;
      longint w1;
      longint q;
      x = longint'(s) * 65536;
      y = x;
      for (int k = 0; k < SECTIONS; k++) begin
         w0 = delay_bank[k*2];
         w1 = delay_bank[k*2+1];
         w = clamp_word(x - coef_product(coef_bank[k*NCOEF+COEF_A1], w0)
                          - coef_product(coef_bank[k*NCOEF+COEF_A2], w1));
         y = clamp_word(coef_product(coef_bank[k*NCOEF+COEF_B0], w)
                        + coef_product(coef_bank[k*NCOEF+COEF_B1], w0)
                        + coef_product(coef_bank[k*NCOEF+COEF_B2], w1));
         delay_bank[k*2+1] = w0;
         delay_bank[k*2] = w;
         x = y;
      end
      q = ((y < 0) ? -y : y) >>> 16;
      if (y < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   task automatic send_word(input bit mode, input logic [15:0] smp, input logic [3:0] sec,
                            input logic [2:0] sel, input logic [31:0] val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_sample_in <= 16'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_sample_in <= smp;
      req_coef_section <= sec;
      req_coef_select <= sel;
      req_coef_value <= val;
      do @(posedge clock); while (!req_ready);
      if (mode) begin
         if (sel < NCOEF) coef_bank[sec*NCOEF+sel] = val;
      end else begin
         filtered_q.push_back(filter_sample(smp));
      end
   endtask

   task automatic send_sample(input logic [15:0] smp);
      send_word(1'b0, smp, 4'($urandom), 3'($urandom), $urandom);
   endtask

   task automatic send_coef(input logic [3:0] sec, input logic [2:0] sel,
                            input logic [31:0] val);
      send_word(1'b1, 16'($urandom), sec, sel, val);
   endtask

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom;
         3: return 32'h0100_0000;
         default: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
      endcase
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_q.size() == 0) begin
            $error("sample_out: unexpected word, actual %0d", rsp_sample_out);
            error_count++;
         end else begin
            if (rsp_sample_out !== filtered_q[0]) begin
               $error("sample_out: expected %0d, actual %0d",
                      $signed(filtered_q[0]), rsp_sample_out);
               error_count++;
            end
            void'(filtered_q.pop_front());
         end
      end
   end

   task automatic test_directed();
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_coef(4'd3, 3'd5, 32'h0100_0000);
      send_coef(4'd0, 3'd7, 32'h7FFF_FFFF);
      send_sample(16'h0000);
      for (int k = 0; k < SECTIONS; k++) send_coef(4'(k), COEF_B0, 32'h7FFF_FFFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_coef(4'd15, COEF_A1, 32'h8000_0000);
      send_coef(4'd15, COEF_A2, 32'h7FFF_FFFF);
      send_sample(16'h0001);
   endtask

   task automatic test_random(input int items, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(99) < 30) begin
            send_sample(pick_sample());
         end else begin
            send_coef(4'($urandom),
                      3'(($urandom_range(9) == 0) ? $urandom_range(7, 5)
                                                  : $urandom_range(4)),
                      pick_coef());
         end
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b1;
      for (int n = 0; n < 6; n++) begin
         send_sample(pick_sample());
         send_coef(4'($urandom), 3'($urandom_range(4)), pick_coef());
      end
   endtask

   initial begin
      for (int k = 0; k < SECTIONS*NCOEF; k++) coef_bank[k] = '0;
      for (int k = 0; k < SECTIONS*2; k++) delay_bank[k] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(450, 0, 0);
      test_random(450, 70, 0);
      test_random(450, 0, 70);
      test_random(450, 10, 10);
      test_backpressure();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (filtered_q.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #400ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/iirbq_pkg.sv
rtl/core/iir_biquad_cascade_unit.sv
test/tb_iir_biquad_cascade_unit.sv
